// ===== design/sfd_pkg.sv =====
package sfd_pkg;

  localparam int BODY_COUNT_BITS_DEF = 17;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [7:0] ESC_DELIM_CODE = 8'h5E;
  localparam logic [7:0] ESC_ESC_CODE = 8'h5D;
  localparam int MIN_BODY = 8;
  localparam int PAY_START = 4;

  localparam logic [7:0] DELIM_RST = 8'h7E;
  localparam logic [7:0] ESC_RST = 8'h7D;
  localparam logic [7:0] VER_RST = 8'h01;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    REG_DELIMITER = 2'd0,
    REG_ESCAPE    = 2'd1,
    REG_VERSION   = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_ESCAPE = 3'd1,
    ST_TOO_SHORT  = 3'd2,
    ST_BAD_VER    = 3'd3,
    ST_LEN_MISM   = 3'd4,
    ST_CRC_MISM   = 3'd5
  } status_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_t;

  typedef struct packed {
    logic [7:0] delimiter_code;
    logic [7:0] escape_code;
    logic [7:0] expected_version;
  } cfg_t;

  typedef struct packed {
    kind_t      result_kind;
    logic [7:0] payload_byte;
    status_t    frame_status;
    logic [7:0] frame_version;
    logic [7:0] frame_flags;
    logic       last_of_run;
  } result_t;

  function automatic logic [31:0] crc32_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== design/sfd_core.sv =====
module sfd_core #(
  parameter int BODY_COUNT_BITS = sfd_pkg::BODY_COUNT_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  logic [7:0]       data_byte,
  input  logic             frame_end,
  input  sfd_pkg::cfg_t    cfg,
  output sfd_pkg::result_t res_a,
  output sfd_pkg::result_t res_b,
  output logic [1:0]       push_cnt
);

  logic                       esc_pend_r, esc_pend_nxt;
  logic                       esc_err_r, esc_err_nxt;
  logic [BODY_COUNT_BITS-1:0] count_r, count_nxt;
  logic [7:0]                 tail_r [4];
  logic [7:0]                 tail_nxt [4];
  logic [31:0]                crc_r, crc_nxt;
  logic [7:0]                 ver_r, ver_nxt;
  logic [7:0]                 flags_r, flags_nxt;
  logic [15:0]                len_r, len_nxt;

  logic                       body_en;
  logic [7:0]                 body_b;
  logic                       emit;
  logic [31:0]                crc_rx;
  logic [BODY_COUNT_BITS-1:0] len_plus;
  sfd_pkg::status_t           status;
  sfd_pkg::result_t           pay_res, stat_res;

  always_comb begin
    body_en = 1'b0;
    body_b = data_byte;
    esc_pend_nxt = esc_pend_r;
    esc_err_nxt = esc_err_r;
    if (!esc_err_r) begin
      if (esc_pend_r) begin
        esc_pend_nxt = 1'b0;
        if (data_byte == sfd_pkg::ESC_DELIM_CODE) begin
          body_en = 1'b1;
          body_b = cfg.delimiter_code;
        end else if (data_byte == sfd_pkg::ESC_ESC_CODE) begin
          body_en = 1'b1;
          body_b = cfg.escape_code;
        end else begin
          esc_err_nxt = 1'b1;
        end
      end else if (data_byte == cfg.escape_code) begin
        esc_pend_nxt = 1'b1;
      end else begin
        body_en = 1'b1;
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    crc_nxt = crc_r;
    ver_nxt = ver_r;
    flags_nxt = flags_r;
    len_nxt = len_r;
    tail_nxt = tail_r;
    emit = 1'b0;
    if (body_en) begin
      if (count_r == BODY_COUNT_BITS'(0)) begin
        ver_nxt = body_b;
      end else if (count_r == BODY_COUNT_BITS'(1)) begin
        flags_nxt = body_b;
      end else if (count_r == BODY_COUNT_BITS'(2)) begin
        len_nxt[15:8] = body_b;
      end else if (count_r == BODY_COUNT_BITS'(3)) begin
        len_nxt[7:0] = body_b;
      end
      if (count_r >= BODY_COUNT_BITS'(sfd_pkg::PAY_START)) begin
        crc_nxt = sfd_pkg::crc32_byte(crc_r, tail_r[0]);
        emit = (count_r >= BODY_COUNT_BITS'(sfd_pkg::MIN_BODY));
      end
      tail_nxt[0] = tail_r[1];
      tail_nxt[1] = tail_r[2];
      tail_nxt[2] = tail_r[3];
      tail_nxt[3] = body_b;
      if (count_r != {BODY_COUNT_BITS{1'b1}}) begin
        count_nxt = count_r + BODY_COUNT_BITS'(1);
      end
    end
  end

  assign crc_rx = {tail_nxt[0], tail_nxt[1], tail_nxt[2], tail_nxt[3]};
  assign len_plus = BODY_COUNT_BITS'(len_nxt) + BODY_COUNT_BITS'(sfd_pkg::MIN_BODY);

  always_comb begin
    if (esc_err_nxt || esc_pend_nxt) begin
      status = sfd_pkg::ST_BAD_ESCAPE;
    end else if (count_nxt < BODY_COUNT_BITS'(sfd_pkg::MIN_BODY)) begin
      status = sfd_pkg::ST_TOO_SHORT;
    end else if (ver_nxt != cfg.expected_version) begin
      status = sfd_pkg::ST_BAD_VER;
    end else if (count_nxt != len_plus) begin
      status = sfd_pkg::ST_LEN_MISM;
    end else if (~crc_nxt != crc_rx) begin
      status = sfd_pkg::ST_CRC_MISM;
    end else begin
      status = sfd_pkg::ST_OK;
    end
  end

  always_comb begin
    pay_res.result_kind = sfd_pkg::KIND_PAYLOAD;
    pay_res.payload_byte = tail_r[0];
    pay_res.frame_status = sfd_pkg::ST_OK;
    pay_res.frame_version = 8'd0;
    pay_res.frame_flags = 8'd0;
    pay_res.last_of_run = ~frame_end;

    stat_res.result_kind = sfd_pkg::KIND_STATUS;
    stat_res.payload_byte = 8'd0;
    stat_res.frame_status = status;
    stat_res.frame_version = ver_nxt;
    stat_res.frame_flags = flags_nxt;
    stat_res.last_of_run = 1'b1;
  end

  assign res_a = emit ? pay_res : stat_res;
  assign res_b = stat_res;
  assign push_cnt = advance ? (2'(emit) + 2'(frame_end)) : 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n || (advance && frame_end)) begin
      esc_pend_r <= 1'b0;
      esc_err_r <= 1'b0;
      count_r <= '0;
      for (int i = 0; i < 4; i++) begin
        tail_r[i] <= 8'd0;
      end
      crc_r <= sfd_pkg::CRC_INIT;
      ver_r <= 8'd0;
      flags_r <= 8'd0;
      len_r <= 16'd0;
    end else if (advance) begin
      esc_pend_r <= esc_pend_nxt;
      esc_err_r <= esc_err_nxt;
      count_r <= count_nxt;
      tail_r <= tail_nxt;
      crc_r <= crc_nxt;
      ver_r <= ver_nxt;
      flags_r <= flags_nxt;
      len_r <= len_nxt;
    end
  end

endmodule

// ===== design/sfd_result_fifo.sv =====
module sfd_result_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [1:0]       push_cnt,
  input  sfd_pkg::result_t push_a,
  input  sfd_pkg::result_t push_b,
  input  logic             out_ready,
  output logic             out_valid,
  output sfd_pkg::result_t out_res,
  output logic             room2
);

  sfd_pkg::result_t                   mem [sfd_pkg::FIFO_DEPTH];
  logic [sfd_pkg::FIFO_PTR_BITS-1:0]  wr_ptr_r, rd_ptr_r;
  logic [sfd_pkg::FIFO_CNT_BITS-1:0]  count_r;
  logic                               pop;

  assign out_valid = (count_r != '0);
  assign out_res = mem[rd_ptr_r];
  assign pop = out_valid && out_ready;
  assign room2 = (count_r <= sfd_pkg::FIFO_CNT_BITS'(sfd_pkg::FIFO_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wr_ptr_r] <= push_a;
    end
    if (push_cnt == 2'd2) begin
      mem[wr_ptr_r + sfd_pkg::FIFO_PTR_BITS'(1)] <= push_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + sfd_pkg::FIFO_PTR_BITS'(push_cnt);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + sfd_pkg::FIFO_PTR_BITS'(1);
      end
      count_r <= count_r + sfd_pkg::FIFO_CNT_BITS'(push_cnt)
                 - sfd_pkg::FIFO_CNT_BITS'(pop);
    end
  end

endmodule

// ===== design/stuffed_frame_decoder_crc32.sv =====
// Byte-stuffed frame decoder with CRC-32 check. Each input item is one encoded
// byte of a frame (delimiter removed, last byte flagged by in_frame_end). Every
// item passes an input register, is unstuffed and checked, and its results go
// into a four-entry result queue, so an item can be accepted every cycle while
// the queue has room for two results. An item yields zero, one or two results
// (a payload byte and, on the last byte, a status item); the result port
// delivers one result per cycle while out_ready is high. Results reach the port
// through the input register and the result queue. Payload bytes are tentative
// and must be dropped by the consumer when the frame status is not ok.
module stuffed_frame_decoder_crc32 #(
  parameter int BODY_COUNT_BITS = sfd_pkg::BODY_COUNT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,

  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_frame_end,

  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_result_kind,
  output logic [7:0] out_payload_byte,
  output logic [2:0] out_frame_status,
  output logic [7:0] out_frame_version,
  output logic [7:0] out_frame_flags,
  output logic       out_last_of_run,

  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata
);

  sfd_pkg::cfg_t    cfg_r;
  logic             in_valid_r;
  logic [7:0]       in_data_r;
  logic             in_end_r;
  logic             advance;
  logic             room2;
  logic [1:0]       push_cnt;
  sfd_pkg::result_t res_a, res_b, out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delimiter_code <= sfd_pkg::DELIM_RST;
      cfg_r.escape_code <= sfd_pkg::ESC_RST;
      cfg_r.expected_version <= sfd_pkg::VER_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sfd_pkg::REG_DELIMITER: cfg_r.delimiter_code <= cfg_wdata;
        sfd_pkg::REG_ESCAPE:    cfg_r.escape_code <= cfg_wdata;
        sfd_pkg::REG_VERSION:   cfg_r.expected_version <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign advance = in_valid_r && room2;
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data_byte;
      in_end_r <= in_frame_end;
    end
  end

  sfd_core #(
    .BODY_COUNT_BITS(BODY_COUNT_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .data_byte (in_data_r),
    .frame_end (in_end_r),
    .cfg       (cfg_r),
    .res_a     (res_a),
    .res_b     (res_b),
    .push_cnt  (push_cnt)
  );

  sfd_result_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push_a    (res_a),
    .push_b    (res_b),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_res   (out_res),
    .room2     (room2)
  );

  assign out_result_kind = out_res.result_kind;
  assign out_payload_byte = out_res.payload_byte;
  assign out_frame_status = out_res.frame_status;
  assign out_frame_version = out_res.frame_version;
  assign out_frame_flags = out_res.frame_flags;
  assign out_last_of_run = out_res.last_of_run;

endmodule
